// File: design/vgts_pkg.sv
// Shared types, constants and helpers for the voxel grid trilinear sampler.
package vgts_pkg;

  localparam int unsigned GridSide = 64;
  localparam int unsigned CoordW   = $clog2(GridSide);
  localparam int unsigned AddrW    = 3 * CoordW;
  localparam int unsigned Depth    = GridSide * GridSide * GridSide;
  localparam int unsigned DimW     = 7;
  localparam int unsigned CfgIdxW  = 3;

  typedef enum logic [1:0] {
    FUNC_SAMPLE = 2'd0,
    FUNC_WRITE  = 2'd1,
    FUNC_FILL   = 2'd2,
    FUNC_NONE   = 2'd3
  } func_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_DIM_X    = 3'd0,
    REG_DIM_Y    = 3'd1,
    REG_DIM_Z    = 3'd2,
    REG_ORIGIN_X = 3'd3,
    REG_ORIGIN_Y = 3'd4,
    REG_ORIGIN_Z = 3'd5,
    REG_INV_SP   = 3'd6,
    REG_UNUSED   = 3'd7
  } reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_AXIS,
    ST_READ,
    ST_BLEND,
    ST_BLEND_Y,
    ST_BLEND_Z,
    ST_FILL,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [1:0]        func;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [5:0]        cell_i;
    logic [5:0]        cell_j;
    logic [5:0]        cell_k;
    logic signed [31:0] value;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] sample_value;
    logic               in_range;
  } out_word_t;

  // Memory port request from the sequencer.
  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] addr;
    logic [31:0]      wdata;
  } mem_req_t;

  // Clamp a dimension register to the grid side.
  function automatic logic [CoordW:0] eff_dim(input logic [DimW-1:0] d);
    logic [CoordW:0] r;
    if (32'(d) > GridSide) r = (CoordW+1)'(GridSide);
    else r = (CoordW+1)'(d);
    return r;
  endfunction

  // (a*(65536-f) + b*f + 32768) >> 16 on biased 32-bit values.
  function automatic logic [31:0] lerp(input logic [31:0] a, input logic [31:0] b,
                                       input logic [15:0] f);
    logic [49:0] s;
    s = 50'(a) * 50'(17'h10000 - 17'(f)) + 50'(b) * 50'(f) + 50'd32768;
    return s[47:16];
  endfunction

endpackage

// File: design/vgts_ram.sv
// Single-port voxel store with registered read.
module vgts_ram (
  input  logic                  clk_i,
  input  vgts_pkg::mem_req_t    req_i,
  output logic [31:0]           rdata_o
);
  import vgts_pkg::*;

  logic [31:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (req_i.we) mem_q[req_i.addr] <= req_i.wdata;
    rdata_o <= mem_q[req_i.addr];
  end

endmodule

// File: design/vgts_axis.sv
// Per-axis offset, scale and floor: cell index, fraction and range flag.
module vgts_axis (
  input  logic                  clk_i,
  input  logic signed [31:0]    pos_i,
  input  logic signed [31:0]    org_i,
  input  logic [31:0]           inv_i,
  input  logic [vgts_pkg::CoordW:0] dim_i,
  output logic [vgts_pkg::CoordW-1:0] cell_o,
  output logic [15:0]           frac_o,
  output logic                  ok_o
);
  import vgts_pkg::*;

  logic signed [32:0] d_q;
  logic [63:0]        p;
  logic               neg;

  always_ff @(posedge clk_i) begin
    d_q <= 33'(pos_i) - 33'(org_i);
  end

  // Offset below 2^32 times 32-bit scale: one 32x32 product.
  assign neg    = d_q[32];
  assign p      = 64'(d_q[31:0]) * 64'(inv_i);
  assign ok_o   = !neg && (p[63:32] < 32'(dim_i));
  assign cell_o = p[32+CoordW-1:32];
  assign frac_o = p[31:16];

endmodule

// File: design/voxel_grid_trilinear_sampler.sv
// Top level: command sequencer, corner fetch and three-stage blend around the voxel store.
// Sample: axis, corner reads (8 issues, last return, settle), blend, done; done_o is
// registered from the done state and the next word can be taken while it is high: one sample at a time.
// Sample outside the grid: axis, then done. Write or no-op: straight to done. Fill: one cell per cycle.
// Reset clears control and registers to defaults; voxel contents stay unknown.
// Results appear for one cycle on done_o; the receiver cannot stall.
module voxel_grid_trilinear_sampler (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  vgts_pkg::in_word_t   in_i,
  output logic                 done_o,
  output vgts_pkg::out_word_t  out_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [vgts_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [31:0]          cfg_data_i
);
  import vgts_pkg::*;

  logic [DimW-1:0] dim_x_q, dim_y_q, dim_z_q;
  logic [31:0]     org_x_q, org_y_q, org_z_q, inv_q;
  state_e          st_q, st_d;
  in_word_t        cmd_q;
  logic [AddrW-1:0] cnt_q, cnt_d;
  logic [3:0]      rd_q, rd_d;     // corner issue index, 8 = finished issuing
  logic            rv_q;           // read in flight
  logic [2:0]      rc_q;           // corner of read in flight
  logic            rz_q;           // corner in flight is out of grid
  logic [31:0]     c_q [8];
  logic [CoordW:0] nx, ny, nz;
  logic [CoordW-1:0] ci, cj, ck;
  logic [15:0]     fx, fy, fz;
  logic            okx, oky, okz;
  logic [CoordW-1:0] ci_q, cj_q, ck_q;
  logic [15:0]     fx_q, fy_q, fz_q;
  logic [31:0]     rdata;
  mem_req_t        req;
  out_word_t       res_d, res_q;
  logic            done_q;
  logic [CoordW:0] ix, jy, kz;
  logic            cz;
  logic [31:0]     la, lb, lc, ld, le, lg, lr;
  logic [31:0]     lx_q [4];
  logic [31:0]     ly_q [2];

  assign nx = eff_dim(dim_x_q);
  assign ny = eff_dim(dim_y_q);
  assign nz = eff_dim(dim_z_q);

  assign cfg_ready_o = (st_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_x_q <= DimW'(64); dim_y_q <= DimW'(64); dim_z_q <= DimW'(64);
      org_x_q <= '0; org_y_q <= '0; org_z_q <= '0;
      inv_q   <= 32'h0001_0000;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (reg_e'(cfg_idx_i))
        REG_DIM_X:    dim_x_q <= cfg_data_i[DimW-1:0];
        REG_DIM_Y:    dim_y_q <= cfg_data_i[DimW-1:0];
        REG_DIM_Z:    dim_z_q <= cfg_data_i[DimW-1:0];
        REG_ORIGIN_X: org_x_q <= cfg_data_i;
        REG_ORIGIN_Y: org_y_q <= cfg_data_i;
        REG_ORIGIN_Z: org_z_q <= cfg_data_i;
        REG_INV_SP:   inv_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  vgts_axis u_ax (.clk_i, .pos_i(in_i.pos_x), .org_i(org_x_q), .inv_i(inv_q), .dim_i(nx),
                  .cell_o(ci), .frac_o(fx), .ok_o(okx));
  vgts_axis u_ay (.clk_i, .pos_i(in_i.pos_y), .org_i(org_y_q), .inv_i(inv_q), .dim_i(ny),
                  .cell_o(cj), .frac_o(fy), .ok_o(oky));
  vgts_axis u_az (.clk_i, .pos_i(in_i.pos_z), .org_i(org_z_q), .inv_i(inv_q), .dim_i(nz),
                  .cell_o(ck), .frac_o(fz), .ok_o(okz));

  vgts_ram u_ram (.clk_i, .req_i(req), .rdata_o(rdata));

  // Corner under issue: bit0 -> +x, bit1 -> +y, bit2 -> +z.
  assign ix = (CoordW+1)'(ci_q) + (CoordW+1)'(rd_q[0]);
  assign jy = (CoordW+1)'(cj_q) + (CoordW+1)'(rd_q[1]);
  assign kz = (CoordW+1)'(ck_q) + (CoordW+1)'(rd_q[2]);
  assign cz = (ix >= nx) || (jy >= ny) || (kz >= nz);

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_IDLE: begin
        if (start) begin
          unique case (func_e'(in_i.func))
            FUNC_SAMPLE: st_d = ST_AXIS;
            FUNC_FILL:   st_d = ST_FILL;
            FUNC_WRITE:  st_d = ST_DONE;
            FUNC_NONE:   st_d = ST_DONE;
          endcase
        end
      end
      ST_AXIS:    st_d = (okx && oky && okz) ? ST_READ : ST_DONE;
      ST_READ:    if (rd_q == 4'd8 && !rv_q) st_d = ST_BLEND;
      ST_BLEND:   st_d = ST_BLEND_Y;
      ST_BLEND_Y: st_d = ST_BLEND_Z;
      ST_BLEND_Z: st_d = ST_DONE;
      ST_FILL:    if (cnt_q == AddrW'(Depth - 1)) st_d = ST_DONE;
      ST_DONE:    st_d = ST_IDLE;
      default:    st_d = ST_IDLE;
    endcase
  end

  always_comb begin
    req       = '0;
    req.addr  = {kz[CoordW-1:0], jy[CoordW-1:0], ix[CoordW-1:0]};
    req.wdata = cmd_q.value;
    cnt_d     = cnt_q;
    rd_d      = rd_q;
    unique case (st_q)
      ST_IDLE: begin
        cnt_d = '0;
        rd_d  = '0;
        // Writes go straight in at accept time.
        req.addr  = {in_i.cell_k, in_i.cell_j, in_i.cell_i};
        req.wdata = in_i.value;
        req.we    = start && (func_e'(in_i.func) == FUNC_WRITE) &&
                    (7'(in_i.cell_i) < 7'(nx)) && (7'(in_i.cell_j) < 7'(ny)) &&
                    (7'(in_i.cell_k) < 7'(nz));
      end
      ST_READ: if (rd_q != 4'd8) rd_d = rd_q + 4'd1;
      ST_FILL: begin
        req.we   = 1'b1;
        req.addr = cnt_q;
        cnt_d    = cnt_q + AddrW'(1);
      end
      default: ;
    endcase
  end

  // Blend one axis per cycle: x, then y, then z.
  assign la = lerp(c_q[0], c_q[1], fx_q);
  assign lb = lerp(c_q[2], c_q[3], fx_q);
  assign lc = lerp(c_q[4], c_q[5], fx_q);
  assign ld = lerp(c_q[6], c_q[7], fx_q);
  assign le = lerp(lx_q[0], lx_q[1], fy_q);
  assign lg = lerp(lx_q[2], lx_q[3], fy_q);
  assign lr = lerp(ly_q[0], ly_q[1], fz_q);

  always_comb begin
    res_d = '0;
    priority if (st_q == ST_BLEND_Z) begin
      res_d.sample_value = lr ^ 32'h8000_0000;
      res_d.in_range     = 1'b1;
    end else if (st_q == ST_IDLE) begin
      res_d.in_range = (func_e'(in_i.func) == FUNC_WRITE) &&
                       (7'(in_i.cell_i) < 7'(nx)) && (7'(in_i.cell_j) < 7'(ny)) &&
                       (7'(in_i.cell_k) < 7'(nz));
    end else begin
      res_d = res_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= ST_IDLE;
      cnt_q  <= '0;
      rd_q   <= '0;
      rv_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      cnt_q  <= cnt_d;
      rd_q   <= rd_d;
      rv_q   <= (st_q == ST_READ) && (rd_q != 4'd8);
      done_q <= (st_q == ST_DONE);
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == ST_IDLE && start) cmd_q <= in_i;
    if (st_q == ST_AXIS) begin
      ci_q <= ci; cj_q <= cj; ck_q <= ck;
      fx_q <= fx; fy_q <= fy; fz_q <= fz;
    end
    rc_q  <= rd_q[2:0];
    rz_q  <= cz;
    // Bias the returned corner; out-of-grid corners read as bias only.
    if (rv_q) c_q[rc_q] <= rz_q ? 32'h8000_0000 : (rdata ^ 32'h8000_0000);
    if (st_q == ST_BLEND) begin
      lx_q[0] <= la; lx_q[1] <= lb; lx_q[2] <= lc; lx_q[3] <= ld;
    end
    if (st_q == ST_BLEND_Y) begin
      ly_q[0] <= le; ly_q[1] <= lg;
    end
    if (st_q != ST_DONE) res_q <= res_d;
  end

  assign busy   = (st_q != ST_IDLE);
  assign done_o = done_q;
  assign out_o  = res_q;

  a_idle_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o == !busy) else $error("cfg ready mismatch");
  a_done_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(st_q == ST_DONE)) else $error("stray done");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("done while busy");
  a_fill_we: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_FILL) |-> req.we) else $error("fill without write");

endmodule

// File: tb/tb_voxel_grid_trilinear_sampler.sv
// Testbench for the voxel grid trilinear sampler: directed table, random phases, scoreboard.
module tb_voxel_grid_trilinear_sampler;
  import vgts_pkg::*;

  localparam int unsigned WatchLimit = 1000000;
  localparam int unsigned PhaseItems = 140;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  in_word_t            in_i = '0;
  logic                done_o;
  out_word_t           out_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [31:0]         cfg_data_i = '0;

  voxel_grid_trilinear_sampler i_dut (
    .clk_i, .rst_ni, .start, .busy, .in_i, .done_o, .out_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_idx_i, .cfg_data_i
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Shadow of the block's registers and voxel store
  logic [6:0]  dim_r [3];
  logic [31:0] org_r [3];
  logic [31:0] inv_r;
  logic [31:0] voxel_mem [Depth];

  out_word_t exp_results [$];
  int unsigned n_err = 0, n_checked = 0, n_items = 0, n_samples_in = 0, n_cfg = 0;
  int unsigned idle_cycles = 0;

  function automatic int unsigned clamp_dim(input logic [6:0] d);
    return (d > 7'(GridSide)) ? GridSide : int'(d);
  endfunction

  function automatic logic locate_axis(input logic [31:0] pos, input logic [31:0] org,
                                       input int unsigned n, output int unsigned cell_idx,
                                       output logic [15:0] fr);
    logic signed [32:0] d;
    logic [63:0] p;
    cell_idx = 0;
    fr = '0;
    d = $signed({pos[31], pos}) - $signed({org[31], org});
    if (d < 0) return 1'b0;
    p = 64'(d[31:0]) * 64'(inv_r);
    if (p[63:32] >= 32'(n)) return 1'b0;
    cell_idx = int'(p[63:32]);
    fr = p[31:16];
    return 1'b1;
  endfunction

  // Biased corner value; past the used grid it is the bias alone
  function automatic logic [63:0] corner_val(input int unsigned i, input int unsigned j,
                                             input int unsigned k, input int unsigned nx,
                                             input int unsigned ny, input int unsigned nz);
    if (i >= nx || j >= ny || k >= nz) return 64'h8000_0000;
    return {32'b0, voxel_mem[i + GridSide * (j + GridSide * k)] ^ 32'h8000_0000};
  endfunction

  function automatic logic [63:0] blend(input logic [63:0] a, input logic [63:0] b,
                                        input logic [15:0] f);
    return (a * (64'd65536 - 64'(f)) + b * 64'(f) + 64'd32768) >> 16;
  endfunction

  // Apply one command to the shadow state and return its result word
  function automatic out_word_t predict_result(input in_word_t w);
    out_word_t r;
    int unsigned nx, ny, nz, i, j, k;
    logic [15:0] fx, fy, fz;
    logic [63:0] a, b, c, d, e, g, v;
    r = '0;
    nx = clamp_dim(dim_r[0]);
    ny = clamp_dim(dim_r[1]);
    nz = clamp_dim(dim_r[2]);
    case (func_e'(w.func))
      FUNC_SAMPLE: begin
        if (locate_axis(w.pos_x, org_r[0], nx, i, fx) &&
            locate_axis(w.pos_y, org_r[1], ny, j, fy) &&
            locate_axis(w.pos_z, org_r[2], nz, k, fz)) begin
          a = blend(corner_val(i, j, k, nx, ny, nz), corner_val(i+1, j, k, nx, ny, nz), fx);
          b = blend(corner_val(i, j+1, k, nx, ny, nz), corner_val(i+1, j+1, k, nx, ny, nz), fx);
          c = blend(corner_val(i, j, k+1, nx, ny, nz), corner_val(i+1, j, k+1, nx, ny, nz), fx);
          d = blend(corner_val(i, j+1, k+1, nx, ny, nz),
                    corner_val(i+1, j+1, k+1, nx, ny, nz), fx);
          e = blend(a, b, fy);
          g = blend(c, d, fy);
          v = blend(e, g, fz);
          r.sample_value = v[31:0] ^ 32'h8000_0000;
          r.in_range = 1'b1;
        end
      end
      FUNC_WRITE: begin
        if (w.cell_i < nx && w.cell_j < ny && w.cell_k < nz) begin
          voxel_mem[w.cell_i + GridSide * (w.cell_j + GridSide * w.cell_k)] = w.value;
          r.in_range = 1'b1;
        end
      end
      FUNC_FILL: begin
        for (int n = 0; n < Depth; n++) voxel_mem[n] = w.value;
      end
      default: ;
    endcase
    return r;
  endfunction

  // Result checker and watchdog, sampled away from the driving edge
  always @(negedge clk_i) begin
    if (done_o || (start && !busy) || (cfg_valid_i && cfg_ready_o)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("watchdog expired with %0d results outstanding", exp_results.size());
      $display("status: fail");
      $finish;
    end
    if (rst_ni && done_o) begin
      if (exp_results.size() == 0) begin
        n_err++;
        if (n_err <= 10) $display("unexpected result word %h", out_o);
      end else begin
        out_word_t x;
        x = exp_results.pop_front();
        n_checked++;
        if (out_o.sample_value !== x.sample_value || out_o.in_range !== x.in_range) begin
          n_err++;
          if (n_err <= 10)
            $display("mismatch: expected value %h range %b, got value %h range %b",
                     x.sample_value, x.in_range, out_o.sample_value, out_o.in_range);
        end
      end
    end
  end

  // Hold valid across a burst of writes; the caller drops it after the last one
  task automatic write_reg(input reg_e idx, input logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    do @(negedge clk_i); while (!cfg_ready_o);
    @(posedge clk_i);
    case (idx)
      REG_DIM_X: dim_r[0] = data[6:0];
      REG_DIM_Y: dim_r[1] = data[6:0];
      REG_DIM_Z: dim_r[2] = data[6:0];
      REG_ORIGIN_X: org_r[0] = data;
      REG_ORIGIN_Y: org_r[1] = data;
      REG_ORIGIN_Z: org_r[2] = data;
      REG_INV_SP: inv_r = data;
      default: ;
    endcase
    n_cfg++;
  endtask

  // Send one command word; start stays high across back-to-back words
  task automatic send_cmd(input in_word_t w, input logic use_fixed, input out_word_t fixed);
    int unsigned gap;
    out_word_t p;
    out_word_t exp_w;
    gap = $urandom_range(0, 13);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    in_i <= w;
    do @(negedge clk_i); while (busy);
    @(posedge clk_i);
    p = predict_result(w);
    exp_w = use_fixed ? fixed : p;
    exp_results = {exp_results, exp_w};
    n_items++;
    if (w.func == FUNC_SAMPLE && p.in_range) n_samples_in++;
  endtask

  task automatic drain();
    start <= 1'b0;
    while (exp_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic apply_setting(input logic [6:0] dx, input logic [6:0] dy, input logic [6:0] dz,
                               input logic [31:0] ox, input logic [31:0] oy,
                               input logic [31:0] oz, input logic [31:0] inv);
    write_reg(REG_DIM_X, {25'($urandom), dx});
    write_reg(REG_DIM_Y, {25'($urandom), dy});
    write_reg(REG_DIM_Z, {25'($urandom), dz});
    write_reg(REG_ORIGIN_X, ox);
    write_reg(REG_ORIGIN_Y, oy);
    write_reg(REG_ORIGIN_Z, oz);
    write_reg(REG_INV_SP, inv);
    cfg_valid_i <= 1'b0;
  endtask

  // Position that lands inside the used grid on one axis when possible
  function automatic logic [31:0] aim_axis(input int a);
    int unsigned n;
    logic [63:0] t, d;
    n = clamp_dim(dim_r[a]);
    if (n == 0 || inv_r == 0) return org_r[a] + $urandom_range(0, 32'h0004_0000);
    t = 64'($urandom_range(0, n * 65536 - 1)) << 16;
    d = t / 64'(inv_r);
    if (d > 64'hFFFF_FFFF) d = 64'($urandom);
    return org_r[a] + d[31:0];
  endfunction

  task automatic random_phase(input int unsigned count);
    in_word_t w;
    int unsigned kind;
    for (int unsigned n = 0; n < count; n++) begin
      w = '0;
      w.value = $urandom;
      kind = $urandom_range(0, 99);
      if (kind < 65) begin
        w.func = FUNC_SAMPLE;
        w.pos_x = aim_axis(0);
        w.pos_y = aim_axis(1);
        w.pos_z = aim_axis(2);
        w.cell_i = 6'($urandom);
        w.cell_j = 6'($urandom);
        w.cell_k = 6'($urandom);
      end else if (kind < 90) begin
        w.func = FUNC_WRITE;
        w.pos_x = $urandom;
        w.pos_y = $urandom;
        w.pos_z = $urandom;
        w.cell_i = 6'($urandom_range(0, clamp_dim(dim_r[0]) + 1));
        w.cell_j = 6'($urandom_range(0, clamp_dim(dim_r[1]) + 1));
        w.cell_k = 6'($urandom_range(0, clamp_dim(dim_r[2]) + 1));
      end else begin
        // noise: any field, any function but fill
        w.func = 2'($urandom_range(0, 3));
        if (w.func == FUNC_FILL) w.func = FUNC_NONE;
        w.pos_x = $urandom;
        w.pos_y = $urandom;
        w.pos_z = $urandom;
        w.cell_i = 6'($urandom);
        w.cell_j = 6'($urandom);
        w.cell_k = 6'($urandom);
      end
      send_cmd(w, 1'b0, '0);
    end
    drain();
  endtask

  typedef struct {
    in_word_t  cmd;
    logic      fixed;
    out_word_t res;
  } dir_row_t;

  dir_row_t dir_rows [] = '{
    // fill first so no voxel is ever read unwritten
    '{'{FUNC_FILL, 0, 0, 0, 0, 0, 0, 32'h0012_3456}, 1'b1, '{32'h0, 1'b0}},
    '{'{FUNC_SAMPLE, 32'h0001_8000, 32'h0002_4000, 32'h0003_C000, 0, 0, 0, 0},
      1'b1, '{32'h0012_3456, 1'b1}},
    '{'{FUNC_SAMPLE, 32'hFFFF_FFFF, 32'h0, 32'h0, 0, 0, 0, 0}, 1'b1, '{32'h0, 1'b0}},
    '{'{FUNC_SAMPLE, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 0, 0, 0, 0}, 1'b1, '{32'h0, 1'b0}},
    '{'{FUNC_SAMPLE, 32'h0040_0000, 32'h0, 32'h0, 0, 0, 0, 0}, 1'b1, '{32'h0, 1'b0}},
    '{'{FUNC_WRITE, 0, 0, 0, 6'd0, 6'd0, 6'd0, 32'h7FFF_FFFF}, 1'b1, '{32'h0, 1'b1}},
    '{'{FUNC_WRITE, 0, 0, 0, 6'd1, 6'd0, 6'd0, 32'h8000_0000}, 1'b1, '{32'h0, 1'b1}},
    '{'{FUNC_WRITE, 0, 0, 0, 6'd63, 6'd63, 6'd63, 32'hFFFF_FFFF}, 1'b1, '{32'h0, 1'b1}},
    '{'{FUNC_WRITE, 0, 0, 0, 6'd0, 6'd1, 6'd1, 32'h0000_0001}, 1'b1, '{32'h0, 1'b1}},
    '{'{FUNC_SAMPLE, 32'h0000_0000, 32'h0, 32'h0, 0, 0, 0, 0}, 1'b1, '{32'h7FFF_FFFF, 1'b1}},
    '{'{FUNC_SAMPLE, 32'h0000_8000, 32'h0, 32'h0, 0, 0, 0, 0}, 1'b0, '{32'h0, 1'b0}},
    '{'{FUNC_SAMPLE, 32'h0000_FFFF, 32'h0000_FFFF, 32'h0000_FFFF, 0, 0, 0, 0},
      1'b0, '{32'h0, 1'b0}},
    // corners past the far edge read as zero
    '{'{FUNC_SAMPLE, 32'h003F_C000, 32'h003F_8000, 32'h003F_4000, 0, 0, 0, 0},
      1'b0, '{32'h0, 1'b0}},
    '{'{FUNC_SAMPLE, 32'h003F_0000, 32'h003F_0000, 32'h003F_0000, 0, 0, 0, 0},
      1'b1, '{32'hFFFF_FFFF, 1'b1}},
    '{'{FUNC_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd63, 6'd63, 6'd63,
        32'hFFFF_FFFF}, 1'b1, '{32'h0, 1'b0}},
    '{'{FUNC_SAMPLE, 32'h0010_0000, 32'h0020_0000, 32'h0030_0000, 0, 0, 0, 0},
      1'b1, '{32'h0012_3456, 1'b1}}
  };

  initial begin
    dim_r = '{7'd64, 7'd64, 7'd64};
    org_r = '{32'h0, 32'h0, 32'h0};
    inv_r = 32'h0001_0000;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[r]) send_cmd(dir_rows[r].cmd, dir_rows[r].fixed, dir_rows[r].res);
    drain();

    // writes outside a small grid are dropped
    apply_setting(7'd2, 7'd3, 7'd4, 32'h0, 32'h0, 32'h0, 32'h0001_0000);
    send_cmd('{FUNC_WRITE, 0, 0, 0, 6'd2, 6'd0, 6'd0, 32'h5}, 1'b1, '{32'h0, 1'b0});
    send_cmd('{FUNC_WRITE, 0, 0, 0, 6'd0, 6'd3, 6'd0, 32'h5}, 1'b1, '{32'h0, 1'b0});
    send_cmd('{FUNC_WRITE, 0, 0, 0, 6'd0, 6'd0, 6'd4, 32'h5}, 1'b1, '{32'h0, 1'b0});
    send_cmd('{FUNC_SAMPLE, 32'h0002_0000, 0, 0, 0, 0, 0, 0}, 1'b1, '{32'h0, 1'b0});
    random_phase(PhaseItems);

    apply_setting(7'd64, 7'd64, 7'd64, 32'h0, 32'h0, 32'h0, 32'h0001_0000);
    random_phase(PhaseItems);
    apply_setting(7'd1, 7'd1, 7'd1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  32'hFFFF_FFFF);
    random_phase(PhaseItems / 2);
    apply_setting(7'd0, 7'd0, 7'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h1);
    random_phase(PhaseItems / 4);
    apply_setting(7'd127, 7'd5, 7'd100, 32'hFFF0_0000, 32'h0001_0000, 32'h0, 32'h0);
    random_phase(PhaseItems / 4);

    // second fill with a random value, then keep sampling over it
    send_cmd('{FUNC_FILL, 0, 0, 0, 0, 0, 0, $urandom}, 1'b1, '{32'h0, 1'b0});
    drain();
    for (int ph = 0; ph < 4; ph++) begin
      apply_setting(7'($urandom_range(1, 70)), 7'($urandom_range(1, 70)),
                    7'($urandom_range(1, 70)), $urandom, $urandom,
                    $urandom, $urandom_range(32'h0000_4000, 32'h0010_0000));
      random_phase(PhaseItems);
    end

    $display("covered %0d command words (%0d samples inside the grid), %0d register writes",
             n_items, n_samples_in, n_cfg);
    $display("checked %0d result words, %0d mismatches", n_checked, n_err);
    if (n_err == 0 && exp_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
